// ----- rtl/slt_pkg.sv -----
// Package: shared types, codes and sizes for the sorted leaf table.
package slt_pkg;

  localparam int unsigned Depth   = 64;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned CntW    = IdxW + 1;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned ValW    = 64;
  localparam int unsigned PageW   = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    FN_LOOKUP = 3'd0,
    FN_INSERT = 3'd1,
    FN_REMOVE = 3'd2,
    FN_READ   = 3'd3,
    FN_SPLIT  = 3'd4,
    FN_APPEND = 3'd5,
    FN_SETNXT = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ABSENT   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOSPLIT  = 3'd3,
    ST_BADIDX   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,   // search: memory read in flight
    S_SRCH_CMP,  // search: compare one entry
    S_FIND_RD,   // read the located entry
    S_FIND_CHK,
    S_SHUP_RD,   // shift up: read entry i-1
    S_SHUP_WR,
    S_SHDN_RD,   // shift down: read entry i
    S_SHDN_WR,
    S_SPL_RD,
    S_SPL_OUT,
    S_DONE
  } state_e;

  // Index value meaning "none"
  localparam logic [6:0] NoIdx = 7'h7F;

endpackage

// ----- rtl/slt_mem.sv -----
// Entry store: key and value memory, one write port, one registered read port.
module slt_mem
  import slt_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  idx_t            waddr_i,
  input  logic [KeyW-1:0] wkey_i,
  input  logic [ValW-1:0] wval_i,
  input  idx_t            raddr_i,
  output logic [KeyW-1:0] rkey_o,
  output logic [ValW-1:0] rval_o
);

  logic [KeyW-1:0] key_mem [Depth];
  logic [ValW-1:0] val_mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      val_mem[waddr_i] <= wval_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rkey_o <= key_mem[raddr_i];
    rval_o <= val_mem[raddr_i];
  end

endmodule

// ----- rtl/sorted_leaf_table_top.sv -----
// Top level: sequencer around the entry store, one compare unit and counters.
//
// Usage: raise start with func_i and its operands while busy is low; the
// item is taken at that edge and busy goes high until its last result has
// been shown. Each result appears for one cycle with valid_o high; last_o
// marks the final one. The receiver cannot stall; results are never held.
// max_size_we_i writes the capacity register (clamped to 2..64); use it only
// while idle: the block itself does not enforce this. Run time is set by the
// single read/write port of the entry store: lookup by key reads and compares
// each entry whose key is not above the search key; lookup or read by index
// needs no search; remove is a lookup, then each entry above the removed one
// is shifted down; insert compares each entry not above the key, then shifts
// the entries above the position up; append, set next, full, bad index and
// split refused need no walk; split shows one result a cycle.
// busy drops the cycle after the last result, so the next item may follow.
// Reset clears the entry count, sets the next pointer to all ones and the
// capacity to 64; the entry store itself is not cleared (entries at or above
// the count are never used).
module sorted_leaf_table_top
  import slt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        max_size_we_i,
  input  logic [6:0]  max_size_i,
  input  logic [2:0]  func_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  input  logic signed [6:0]  hint_index_i,
  input  logic signed [31:0] page_id_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic signed [6:0]  index_o,
  output logic [63:0] out_key_o,
  output logic [63:0] out_value_o,
  output logic signed [6:0]  next_index_o,
  output logic signed [31:0] next_page_o,
  output logic [6:0]  entry_count_o,
  output logic        last_o
);

  state_e state_q, state_d;
  logic [6:0] maxsz_q;
  cnt_t count_q, count_d;
  logic [PageW-1:0] nxt_q, nxt_d, oldp_q, oldp_d;
  logic [2:0] fn_q, fn_d;
  logic [63:0] k_q, k_d, v_q, v_d;
  logic [6:0] hint_q, hint_d;
  logic [PageW-1:0] pg_q, pg_d;
  cnt_t i_q, i_d;        // walking index
  cnt_t pos_q, pos_d;    // located / insert position
  cnt_t j_q, j_d;        // split output number

  // result register
  logic r_vld_q, r_vld_d, r_last_q, r_last_d;
  logic [2:0] r_st_q, r_st_d;
  logic [6:0] r_idx_q, r_idx_d, r_nidx_q, r_nidx_d;
  logic [63:0] r_k_q, r_k_d, r_v_q, r_v_d;
  logic [31:0] r_pg_q, r_pg_d;

  logic we;
  idx_t waddr, raddr;
  logic [63:0] wkey, wval, rkey, rval;

  slt_mem u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wkey_i(wkey), .wval_i(wval),
    .raddr_i(raddr), .rkey_o(rkey), .rval_o(rval)
  );

  // capacity clamped to 2..Depth
  cnt_t cap;
  always_comb begin
    if (maxsz_q < 7'd2) cap = CntW'(2);
    else if (maxsz_q > 7'(Depth)) cap = CntW'(Depth);
    else cap = CntW'(maxsz_q);
  end

  function automatic logic hint_i_sign(input logic [6:0] h);
    hint_i_sign = h[6];
  endfunction

  logic hint_neg, hint_bad;
  assign hint_neg = hint_i_sign(hint_q);
  assign hint_bad = hint_neg || (CntW'(hint_q) >= count_q);

  cnt_t mid;
  assign mid = count_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      maxsz_q <= 7'd64;
      count_q <= '0;
      nxt_q   <= '1;
      r_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (max_size_we_i) maxsz_q <= max_size_i;
      count_q <= count_d;
      nxt_q   <= nxt_d;
      r_vld_q <= r_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fn_q <= fn_d; k_q <= k_d; v_q <= v_d; hint_q <= hint_d; pg_q <= pg_d;
    i_q <= i_d; pos_q <= pos_d; j_q <= j_d; oldp_q <= oldp_d;
    r_last_q <= r_last_d; r_st_q <= r_st_d; r_idx_q <= r_idx_d;
    r_nidx_q <= r_nidx_d; r_k_q <= r_k_d; r_v_q <= r_v_d; r_pg_q <= r_pg_d;
  end

  // next-state and datapath sequencing
  always_comb begin
    state_d = state_q;
    count_d = count_q; nxt_d = nxt_q; oldp_d = oldp_q;
    fn_d = fn_q; k_d = k_q; v_d = v_q; hint_d = hint_q; pg_d = pg_q;
    i_d = i_q; pos_d = pos_q; j_d = j_q;
    r_vld_d = 1'b0; r_last_d = 1'b1; r_st_d = ST_OK; r_idx_d = NoIdx;
    r_nidx_d = NoIdx; r_k_d = '0; r_v_d = '0; r_pg_d = nxt_q;
    we = 1'b0; waddr = idx_t'(i_q); wkey = k_q; wval = v_q;
    raddr = idx_t'(i_q);
    case (state_q)
      S_IDLE: begin
        if (start) begin
          fn_d = func_i; k_d = key_i; v_d = value_i; hint_d = hint_index_i;
          pg_d = page_id_i; i_d = '0;
          state_d = S_DONE;
          case (func_i)
            FN_LOOKUP, FN_REMOVE, FN_INSERT: state_d = S_SRCH_RD;
            FN_READ, FN_SPLIT, FN_APPEND, FN_SETNXT: state_d = S_FIND_CHK;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FIND_CHK: begin
        // single-step operations and first checks
        state_d = S_DONE;
        r_vld_d = 1'b1;
        case (fn_q)
          FN_READ: begin
            if (hint_bad) r_st_d = ST_BADIDX;
            else begin
              r_vld_d = 1'b0; pos_d = CntW'(hint_q); i_d = CntW'(hint_q);
              state_d = S_FIND_RD;
            end
          end
          FN_APPEND: begin
            if (count_q >= cap) r_st_d = ST_FULL;
            else begin
              we = 1'b1; waddr = idx_t'(count_q);
              count_d = count_q + 1'b1;
              r_idx_d = 7'(count_q); r_k_d = k_q; r_v_d = v_q;
            end
          end
          FN_SETNXT: begin
            nxt_d = pg_q; r_pg_d = pg_q;
          end
          FN_SPLIT: begin
            if (count_q != cap) r_st_d = ST_NOSPLIT;
            else begin
              r_vld_d = 1'b0; oldp_d = nxt_q; nxt_d = pg_q;
              pos_d = count_q; count_d = mid; i_d = mid; j_d = '0;
              state_d = S_SPL_RD;
            end
          end
          default: r_vld_d = 1'b0;
        endcase
      end
      S_SRCH_RD: begin
        if (fn_q == FN_INSERT && count_q >= cap) begin
          r_vld_d = 1'b1; r_st_d = ST_FULL; state_d = S_DONE;
        end else if (fn_q != FN_INSERT && hint_q != NoIdx) begin
          if (hint_bad) begin
            r_vld_d = 1'b1; r_st_d = ST_BADIDX; state_d = S_DONE;
          end else begin
            i_d = CntW'(hint_q); state_d = S_FIND_RD;
          end
        end else if (i_q >= count_q) begin
          // upper bound reached end
          pos_d = i_q; state_d = S_SRCH_CMP;
        end else state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        // one compare of the shared unit per entry
        if (i_q < count_q && rkey <= k_q) begin
          i_d = i_q + 1'b1; state_d = S_SRCH_RD;
        end else if (fn_q == FN_INSERT) begin
          pos_d = i_q; i_d = count_q; state_d = S_SHUP_RD;
        end else if (i_q == '0) begin
          r_vld_d = 1'b1; r_st_d = ST_ABSENT; state_d = S_DONE;
        end else begin
          i_d = i_q - 1'b1; state_d = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        pos_d = i_q; state_d = S_FIND_CHK;
        // wait for registered read, then check
        state_d = S_DONE;
        r_vld_d = 1'b0;
        state_d = S_SHDN_RD;
        if (fn_q == FN_READ || fn_q == FN_LOOKUP || fn_q == FN_REMOVE)
          state_d = S_SHDN_RD;
      end
      S_SHDN_RD: begin
        // rkey/rval hold entry pos_q on the first visit
        if (i_q == pos_q) begin
          if (fn_q != FN_READ && rkey != k_q) begin
            r_vld_d = 1'b1; r_st_d = ST_ABSENT; state_d = S_DONE;
          end else begin
            r_idx_d = 7'(pos_q); r_k_d = rkey; r_v_d = rval;
            if (fn_q == FN_REMOVE) begin
              // keep result, then shift down
              r_nidx_d = NoIdx;
              r_last_d = 1'b1;
              r_st_d = ST_OK;
              i_d = pos_q + 1'b1;
              r_vld_d = 1'b0;
              state_d = S_SHDN_WR;
            end else begin
              r_vld_d = 1'b1;
              r_nidx_d = (pos_q + 1'b1 < count_q) ? 7'(pos_q + 1'b1) : NoIdx;
              state_d = S_DONE;
            end
          end
          // hold the removed entry in result register while shifting
          if (fn_q == FN_REMOVE) begin
            r_pg_d = nxt_q;
          end
        end else begin
          r_idx_d = r_idx_q; r_k_d = r_k_q; r_v_d = r_v_q;
          we = 1'b1; waddr = idx_t'(i_q - 1'b1); wkey = rkey; wval = rval;
          i_d = i_q + 1'b1; state_d = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        r_idx_d = r_idx_q; r_k_d = r_k_q; r_v_d = r_v_q;
        if (i_q >= count_q) begin
          count_d = count_q - 1'b1;
          r_vld_d = 1'b1; state_d = S_DONE;
        end else state_d = S_SHDN_RD;
      end
      S_SHUP_RD: begin
        if (i_q == pos_q) begin
          we = 1'b1; waddr = idx_t'(pos_q);
          count_d = count_q + 1'b1;
          r_vld_d = 1'b1; r_idx_d = 7'(pos_q); r_k_d = k_q; r_v_d = v_q;
          state_d = S_DONE;
        end else begin
          raddr = idx_t'(i_q - 1'b1); state_d = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        we = 1'b1; waddr = idx_t'(i_q); wkey = rkey; wval = rval;
        i_d = i_q - 1'b1; state_d = S_SHUP_RD;
      end
      S_SPL_RD: begin
        // first read of the upper half: entry mid
        state_d = S_SPL_OUT;
      end
      S_SPL_OUT: begin
        raddr = idx_t'(i_q + 1'b1);
        r_vld_d = 1'b1; r_idx_d = 7'(j_q); r_k_d = rkey; r_v_d = rval;
        r_pg_d = oldp_q;
        if (i_q + 1'b1 == pos_q) begin
          r_last_d = 1'b1; state_d = S_DONE;
        end else begin
          r_last_d = 1'b0; r_nidx_d = 7'(j_q + 1'b1);
          i_d = i_q + 1'b1; j_d = j_q + 1'b1;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs; entry count follows the register after the update
  assign busy          = (state_q != S_IDLE);
  assign valid_o       = r_vld_q;
  assign status_o      = r_st_q;
  assign index_o       = r_idx_q;
  assign out_key_o     = r_k_q;
  assign out_value_o   = r_v_q;
  assign next_index_o  = r_nidx_q;
  assign next_page_o   = r_pg_q;
  assign entry_count_o = 7'(count_q);
  assign last_o        = r_last_q;

endmodule

// ----- sim/testbench.sv -----
// Testbench for the sorted leaf table: queued items, a clocked driver and monitor.
module testbench
  import slt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One item as sent to the block
  typedef struct {
    logic [2:0]  func;
    logic [63:0] key;
    logic [63:0] value;
    logic [6:0]  hint;
    logic [31:0] page;
  } leaf_item_t;

  // One expected result
  typedef struct {
    logic [2:0]  status;
    logic [6:0]  index;
    logic [63:0] okey;
    logic [63:0] oval;
    logic [6:0]  nidx;
    logic [31:0] npage;
    logic [6:0]  cnt;
    logic        last;
  } leaf_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        max_size_we_i = 1'b0;
  logic [6:0]  max_size_i = 7'd64;
  logic [2:0]  func_i = '0;
  logic [63:0] key_i = '0;
  logic [63:0] value_i = '0;
  logic signed [6:0]  hint_index_i = '0;
  logic signed [31:0] page_id_i = '0;
  logic        valid_o;
  logic [2:0]  status_o;
  logic signed [6:0]  index_o;
  logic [63:0] out_key_o;
  logic [63:0] out_value_o;
  logic signed [6:0]  next_index_o;
  logic signed [31:0] next_page_o;
  logic [6:0]  entry_count_o;
  logic        last_o;

  sorted_leaf_table_top i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  logic [63:0]  leaf_keys [64];
  logic [63:0]  leaf_vals [64];
  int unsigned  leaf_cnt;
  logic [31:0]  leaf_next;
  int unsigned  leaf_cap;

  leaf_item_t   pending_items[$];
  leaf_result_t expected_results[$];
  int           fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           idle_enable = 1'b1;
  bit           hold_off = 1'b0;
  int           gap_left = 0;

  function automatic void push_result(logic [2:0] st, int idx, logic [63:0] k, logic [63:0] v,
                                      int ni, logic [31:0] np, bit lst);
    leaf_result_t r;
    r.status = st; r.index = 7'(idx); r.okey = k; r.oval = v; r.nidx = 7'(ni);
    r.npage = np; r.cnt = 7'(leaf_cnt); r.last = lst;
    expected_results.push_back(r);
  endfunction

  // Position of the last entry with key <= k, plus one
  function automatic int upper_pos(logic [63:0] k);
    int i;
    i = 0;
    while (i < leaf_cnt && leaf_keys[i] <= k) i++;
    return i;
  endfunction

  // Returns status; pos valid when ST_OK
  function automatic logic [2:0] find_entry(logic [63:0] k, int hint, output int pos);
    int i;
    pos = -1;
    if (hint == -1) begin
      i = upper_pos(k) - 1;
      if (i < 0) return ST_ABSENT;
    end else if (hint < 0 || hint >= leaf_cnt) begin
      return ST_BADIDX;
    end else begin
      i = hint;
    end
    if (leaf_keys[i] != k) return ST_ABSENT;
    pos = i;
    return ST_OK;
  endfunction

  function automatic int follow_idx(int i);
    return (i + 1 < leaf_cnt) ? i + 1 : -1;
  endfunction

  // Work out the results of one accepted item
  function automatic void predict_leaf(leaf_item_t it);
    int hint, pos, mid, n, j;
    logic [2:0] st;
    logic [63:0] rk, rv;
    logic [31:0] old;
    hint = $signed(it.hint);
    case (it.func)
      FN_LOOKUP: begin
        st = find_entry(it.key, hint, pos);
        if (st != ST_OK) push_result(st, -1, '0, '0, -1, leaf_next, 1'b1);
        else push_result(ST_OK, pos, leaf_keys[pos], leaf_vals[pos], follow_idx(pos),
                         leaf_next, 1'b1);
      end
      FN_INSERT, FN_APPEND: begin
        if (leaf_cnt >= leaf_cap) begin
          push_result(ST_FULL, -1, '0, '0, -1, leaf_next, 1'b1);
        end else begin
          pos = (it.func == FN_INSERT) ? upper_pos(it.key) : leaf_cnt;
          for (int i = leaf_cnt; i > pos; i--) begin
            leaf_keys[i] = leaf_keys[i-1];
            leaf_vals[i] = leaf_vals[i-1];
          end
          leaf_keys[pos] = it.key;
          leaf_vals[pos] = it.value;
          leaf_cnt++;
          push_result(ST_OK, pos, it.key, it.value, -1, leaf_next, 1'b1);
        end
      end
      FN_REMOVE: begin
        st = find_entry(it.key, hint, pos);
        if (st != ST_OK) begin
          push_result(st, -1, '0, '0, -1, leaf_next, 1'b1);
        end else begin
          rk = leaf_keys[pos];
          rv = leaf_vals[pos];
          for (int i = pos + 1; i < leaf_cnt; i++) begin
            leaf_keys[i-1] = leaf_keys[i];
            leaf_vals[i-1] = leaf_vals[i];
          end
          leaf_cnt--;
          push_result(ST_OK, pos, rk, rv, -1, leaf_next, 1'b1);
        end
      end
      FN_READ: begin
        if (hint < 0 || hint >= leaf_cnt) push_result(ST_BADIDX, -1, '0, '0, -1, leaf_next, 1'b1);
        else push_result(ST_OK, hint, leaf_keys[hint], leaf_vals[hint], follow_idx(hint),
                         leaf_next, 1'b1);
      end
      FN_SPLIT: begin
        if (leaf_cnt != leaf_cap) begin
          push_result(ST_NOSPLIT, -1, '0, '0, -1, leaf_next, 1'b1);
        end else begin
          old = leaf_next;
          mid = leaf_cnt / 2;
          n = leaf_cnt - mid;
          leaf_cnt = mid;
          leaf_next = it.page;
          for (j = 0; j < n; j++)
            push_result(ST_OK, j, leaf_keys[mid+j], leaf_vals[mid+j],
                        (j + 1 == n) ? -1 : j + 1, old, j + 1 == n);
        end
      end
      FN_SETNXT: begin
        leaf_next = it.page;
        push_result(ST_OK, -1, '0, '0, -1, leaf_next, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Driver: one item per accepted start, random gaps
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_leaf('{func_i, key_i, value_i, hint_index_i, page_id_i});
        if (idle_enable && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 10);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (!hold_off && pending_items.size() > 0) begin
          leaf_item_t it;
          it = pending_items.pop_front();
          func_i <= it.func; key_i <= it.key; value_i <= it.value;
          hint_index_i <= it.hint; page_id_i <= it.page;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        leaf_result_t e;
        e = expected_results.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); fail_count++;
        end
        if (index_o !== e.index) begin
          $error("index exp %0d got %0d", e.index, index_o); fail_count++;
        end
        if (out_key_o !== e.okey) begin
          $error("out_key exp %h got %h", e.okey, out_key_o); fail_count++;
        end
        if (out_value_o !== e.oval) begin
          $error("out_value exp %h got %h", e.oval, out_value_o); fail_count++;
        end
        if (next_index_o !== e.nidx) begin
          $error("next_index exp %0d got %0d", e.nidx, next_index_o); fail_count++;
        end
        if (next_page_o !== e.npage) begin
          $error("next_page exp %h got %h", e.npage, next_page_o); fail_count++;
        end
        if (entry_count_o !== e.cnt) begin
          $error("entry_count exp %0d got %0d", e.cnt, entry_count_o); fail_count++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); fail_count++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycle_count > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Keys from a small pool so that hits and duplicates are common
  logic [63:0] key_pool [8];

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 7)];
  endfunction

  function automatic leaf_item_t make_item(logic [2:0] f, logic [63:0] k, logic [63:0] v,
                                           int h, logic [31:0] p);
    leaf_item_t it;
    it.func = f; it.key = k; it.value = v; it.hint = 7'(h); it.page = p;
    return it;
  endfunction

  function automatic leaf_item_t random_item();
    int r, h;
    logic [2:0] f;
    r = $urandom_range(0, 99);
    if (r < 35) f = FN_INSERT;
    else if (r < 50) f = FN_LOOKUP;
    else if (r < 62) f = FN_REMOVE;
    else if (r < 72) f = FN_READ;
    else if (r < 80) f = FN_SPLIT;
    else if (r < 88) f = FN_APPEND;
    else if (r < 95) f = FN_SETNXT;
    else f = 3'd7;
    r = $urandom_range(0, 9);
    if (r < 4) h = -1;
    else if (r < 8) h = $urandom_range(0, 20);
    else h = $urandom_range(-64, 63);
    return make_item(f, pick_key(), {$urandom, $urandom}, h, $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned sz);
    @(posedge clk_i);
    max_size_i <= 7'(sz);
    max_size_we_i <= 1'b1;
    @(posedge clk_i);
    max_size_we_i <= 1'b0;
    leaf_cap = (sz < 2) ? 2 : (sz > 64 ? 64 : sz);
  endtask

  int unsigned cap_list [6] = '{2, 127, 5, 64, 0, 9};

  initial begin
    leaf_cnt = 0; leaf_next = '1; leaf_cap = 64;
    for (int i = 0; i < 8; i++) key_pool[i] = (i == 0) ? 64'd0 : (i == 7) ? '1 : {$urandom, $urandom};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed part on an empty leaf, capacity 4
    write_capacity(4);
    pending_items.push_back(make_item(FN_LOOKUP, 64'd5, 0, -1, 0));
    pending_items.push_back(make_item(FN_READ, 0, 0, 0, 0));
    pending_items.push_back(make_item(FN_SPLIT, 0, 0, -1, 32'd7));
    pending_items.push_back(make_item(FN_INSERT, '1, '1, -1, 0));
    pending_items.push_back(make_item(FN_INSERT, 64'd0, 64'd0, -1, 0));
    pending_items.push_back(make_item(FN_INSERT, 64'd0, 64'd1, -1, 0));
    pending_items.push_back(make_item(FN_LOOKUP, 64'd0, 0, -1, 0));
    pending_items.push_back(make_item(FN_LOOKUP, 64'd3, 0, -1, 0));
    pending_items.push_back(make_item(FN_LOOKUP, 64'd0, 0, 2, 0));
    pending_items.push_back(make_item(FN_LOOKUP, 64'd0, 0, -64, 0));
    pending_items.push_back(make_item(FN_READ, 0, 0, 63, 0));
    pending_items.push_back(make_item(FN_READ, 0, 0, 2, 0));
    pending_items.push_back(make_item(FN_APPEND, 64'd9, 64'd9, -1, 0));
    pending_items.push_back(make_item(FN_INSERT, 64'd4, 64'd4, -1, 0));
    pending_items.push_back(make_item(FN_APPEND, 64'd4, 64'd4, -1, 0));
    pending_items.push_back(make_item(FN_SETNXT, 0, 0, -1, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(FN_SPLIT, 0, 0, -1, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(FN_REMOVE, '1, 0, -1, 0));
    pending_items.push_back(make_item(FN_REMOVE, 64'd0, 0, 0, 0));
    pending_items.push_back(make_item(FN_REMOVE, 64'd8, 0, 1, 0));
    pending_items.push_back(make_item(3'd7, 0, 0, 0, 0));
    pending_items.push_back(make_item(FN_SETNXT, 0, 0, -1, 32'h0));
    wait_drained();
    // Random phases over several capacities
    foreach (cap_list[c]) begin
      write_capacity(cap_list[c]);
      // Sender holds off until the leaf is quiet
      if (c == 2) begin
        hold_off = 1'b1;
        wait_drained();
        hold_off = 1'b0;
      end
      if (c == 5) idle_enable = 1'b0;
      for (int n = 0; n < 75; n++) pending_items.push_back(random_item());
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
